/* design/phased_task_dispatcher_assert.svh */
// assertion macros shared by the checker
`ifndef PHASED_TASK_DISPATCHER_ASSERT_SVH
`define PHASED_TASK_DISPATCHER_ASSERT_SVH

// same-cycle implication, off during reset
`define PTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptd check failed");

// next-cycle implication, off during reset
`define PTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptd check failed");

`endif

/* design/ptd_pkg.sv */
package ptd_pkg;

    localparam int MAX_TASKS   = 8;
    localparam int PHASE_COUNT = 4;
    localparam int EVENT_BITS  = 16;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int PH_W  = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;

    localparam logic [15:0] EV_KEEP = 16'((33'd1 << EVENT_BITS) - 33'd1);

    // item kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_PHASE = 3'd2;
    localparam logic [2:0] ST_FIRED     = 3'd3;
    localparam logic [2:0] ST_NOTHING   = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] period_len;
        logic [15:0] trigger_mask;
        logic [2:0]  phase;
        logic [31:0] tick_ms;
        logic [15:0] event_mask;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [15:0] events_out;
        logic        last;
    } result_t;

    typedef struct packed {
        logic ev_hit;
        logic per_hit;
    } fire_t;

endpackage

/* design/ptd_fire_unit.sv */
module ptd_fire_unit (
    input  logic [31:0]         now,
    input  logic [31:0]         ran_at,
    input  logic [31:0]         period,
    input  logic [15:0]         trigger,
    input  logic [15:0]         events,
    output ptd_pkg::fire_t      fire
);
    import ptd_pkg::*;

    logic [31:0] since;

    // wrapping elapsed time since the task last ran
    assign since = now - ran_at;
    assign fire  = '{ev_hit:  ((trigger & events) != 16'd0),
                     per_hit: ((period != 32'd0) && (since >= period))};

endmodule

/* design/phased_task_dispatcher.sv */
// channel   dir   handshake                    payload
// item      in    item_valid / item_stall      item   (ptd_pkg::item_t)
// result    out   result_valid / result_stall  result (ptd_pkg::result_t)
//
// add and tick beats are taken in the idle state; add leaves its result in the output register
// run beats scan the table phase by phase, one table entry per cycle unless the scan is paused,
//   through the shared elapsed-time compare unit
// the output register holds one beat; a stalled result pauses the scan at the next hit
// reset clears time, task count, sequencer and output valid; the table is filled by adds
module phased_task_dispatcher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ptd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ptd_pkg::result_t result
);
    import ptd_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASE_COUNT - 1);

    logic [1:0]       state_reg, state_next;
    logic [31:0]      time_reg, time_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [PH_W-1:0]  ph_reg, ph_next;
    logic [15:0]      ev_reg, ev_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    // task table, written by add beats and by period hits during a scan
    logic [31:0]      period_mem  [MAX_TASKS];
    logic [31:0]      lastrun_mem [MAX_TASKS];
    logic [15:0]      trig_mem    [MAX_TASKS];
    logic [PH_W-1:0]  phase_mem   [MAX_TASKS];

    logic             out_free;
    logic             item_accept;
    logic             add_we;
    logic             lr_we;
    logic             match;
    logic             hit;
    logic             last_idx;
    fire_t            fire;

    assign out_free    = !out_valid_reg || !result_stall;
    assign item_stall  = (state_reg != S_IDLE) || !out_free;
    assign item_accept = item_valid && !item_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // shared compare unit looks at the entry under the scan pointer
    ptd_fire_unit u_fire (
        .now      (time_reg),
        .ran_at   (lastrun_mem[idx_reg]),
        .period   (period_mem[idx_reg]),
        .trigger  (trig_mem[idx_reg]),
        .events   (ev_reg),
        .fire     (fire)
    );

    assign match    = phase_mem[idx_reg] == ph_reg;
    assign hit      = match && (fire.ev_hit || fire.per_hit);
    assign last_idx = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ph_next         = ph_reg;
        ev_next         = ev_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_next        = out_reg;
        add_we          = 1'b0;
        lr_we           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    unique case (item.kind)
                        KIND_ADD:
                        begin
                            out_valid_next = 1'b1;
                            // full table wins over a bad phase
                            priority if (count_reg >= CNT_W'(MAX_TASKS))
                            begin
                                out_next = '{ST_FULL, 3'd0, 16'd0, 1'b1};
                            end
                            else if ({1'b0, item.phase} >= 4'(PHASE_COUNT))
                            begin
                                out_next = '{ST_BAD_PHASE, 3'd0, 16'd0, 1'b1};
                            end
                            else
                            begin
                                add_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                out_next   = '{ST_ADDED, 3'(count_reg[IDX_W-1:0]),
                                               16'd0, 1'b1};
                            end
                        end
                        KIND_TICK:
                        begin
                            time_next = time_reg + item.tick_ms;
                        end
                        KIND_RUN:
                        begin
                            ev_next         = item.event_mask & EV_KEEP;
                            idx_next        = '0;
                            ph_next         = '0;
                            pend_valid_next = 1'b0;
                            state_next      = (count_reg == '0) ? S_FINISH : S_SCAN;
                        end
                        default:
                        begin
                            // unused kind is dropped
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // a hit needs room to push out the held result; otherwise wait
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    lr_we = match && fire.per_hit;
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next = '{ST_FIRED, 3'(pend_idx_reg), ev_reg, 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                    end
                    if (last_idx)
                    begin
                        idx_next = '0;
                        if (ph_reg == PH_LAST)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ph_next = ph_reg + PH_W'(1);
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_FINISH:
            begin
                // the held hit goes out flagged last, or a nothing-fired beat
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = '{ST_FIRED, 3'(pend_idx_reg), ev_reg, 1'b1};
                    end
                    else
                    begin
                        out_next = '{ST_NOTHING, 3'd0, 16'd0, 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            time_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // scan pointers and result payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        ph_reg       <= ph_next;
        ev_reg       <= ev_next;
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
    end

    // table writes; a new task starts with last-run zero
    always_ff @(posedge clk)
    begin
        if (add_we)
        begin
            period_mem[count_reg[IDX_W-1:0]]  <= item.period_len;
            lastrun_mem[count_reg[IDX_W-1:0]] <= '0;
            trig_mem[count_reg[IDX_W-1:0]]    <= item.trigger_mask & EV_KEEP;
            phase_mem[count_reg[IDX_W-1:0]]   <= item.phase[PH_W-1:0];
        end
        else if (lr_we)
        begin
            lastrun_mem[idx_reg] <= time_reg;
        end
    end

endmodule

/* design/ptd_checker.sv */
`include "phased_task_dispatcher_assert.svh"

module ptd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input ptd_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input ptd_pkg::result_t result
);
    import ptd_pkg::*;

    logic item_accept;

    assign item_accept = item_valid && !item_stall;

    // a held result beat stays put
    `PTD_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result))

    // an add beat answers in the next cycle with an add status
    `PTD_ASSERT_NEXT(a_add_answers, item_accept && item.kind == KIND_ADD,
        result_valid && (result.status == ST_ADDED || result.status == ST_FULL ||
        result.status == ST_BAD_PHASE))

    // a run beat keeps the block busy, stalling items in the next cycle
    `PTD_ASSERT_NEXT(a_run_busy, item_accept && item.kind == KIND_RUN, item_stall)

    // non-fired results are single and carry no events
    `PTD_ASSERT_NOW(a_single_result, result_valid && result.status != ST_FIRED,
        result.last && result.events_out == 16'd0)

endmodule

bind phased_task_dispatcher ptd_checker u_ptd_checker (.*);
